### rtl/core/signed_integer_to_radix_digits_core_assert.svh
// Assertion macros for the radix digit core.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequence holds in the same cycle as the condition.
`define SIRD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: consequence does not hold in the same cycle");

// The consequence holds in the cycle after the condition.
`define SIRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: consequence does not hold in the next cycle");

`else

`define SIRD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SIRD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/sird_pkg.sv
package sird_pkg;

  // Default bound on the alphabet size.
  localparam int MAX_RADIX_DEF = 16;

  // Field and register widths.
  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int RADIX_W     = 5;
  localparam int SYM_W       = 64;
  localparam int NUM_SYMS    = 16;
  localparam int SYM_IDX_W   = 4;
  localparam int CFG_INDEX_W = 2;

  // Digit store and sequencer sizes.
  localparam int MAX_DIGITS  = 32;
  localparam int ND_W        = 6;
  localparam int DIGIT_IDX_W = 5;
  localparam int BITCNT_W    = 5;
  localparam int PC_W        = 4;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIX        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  // Register values after reset: radix 10 over the symbols '0' to '7' and then
  // '9' twice, so the reset alphabet holds a repeat.
  localparam logic [RADIX_W-1:0] RADIX_RESET        = 5'd10;
  localparam logic [SYM_W-1:0]   SYMBOLS_LOW_RESET  = 64'd3978425819141910832;
  localparam logic [SYM_W-1:0]   SYMBOLS_HIGH_RESET = 64'd14649;

  // Characters with a special meaning.
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Datapath operation of one microcode step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_CHECK,
    OP_EMIT_ERR,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_PUSH,
    OP_EMIT_SIGN,
    OP_EMIT_DIGIT
  } op_t;

  // Jump condition of one microcode step.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_CHECK_MORE,
    COND_ALPHA_OK,
    COND_DIV_MORE,
    COND_MORE_QUOTIENT,
    COND_MORE_DIGITS
  } cond_t;

  // Step addresses of the program.
  localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] STEP_CHECK    = 4'd1;
  localparam logic [PC_W-1:0] STEP_TEST     = 4'd2;
  localparam logic [PC_W-1:0] STEP_ERR      = 4'd3;
  localparam logic [PC_W-1:0] STEP_DIV_INIT = 4'd4;
  localparam logic [PC_W-1:0] STEP_DIV_STEP = 4'd5;
  localparam logic [PC_W-1:0] STEP_PUSH     = 4'd6;
  localparam logic [PC_W-1:0] STEP_SIGN     = 4'd7;
  localparam logic [PC_W-1:0] STEP_DIGIT    = 4'd8;
  localparam logic [PC_W-1:0] STEP_RETURN   = 4'd9;

  // One control word: the operation, and a jump taken when the condition holds.
  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [PC_W-1:0]   target;
  } ctrl_word_t;

  // Strobes from the sequencer to the divider.
  typedef struct packed {
    logic load;
    logic init;
    logic step;
  } div_ctl_t;

  // The program. A step falls through to the next address unless its jump is taken.
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      STEP_IDLE:     w = '{OP_LOAD,       COND_NO_INPUT,      STEP_IDLE};
      STEP_CHECK:    w = '{OP_CHECK,      COND_CHECK_MORE,    STEP_CHECK};
      STEP_TEST:     w = '{OP_NOP,        COND_ALPHA_OK,      STEP_DIV_INIT};
      STEP_ERR:      w = '{OP_EMIT_ERR,   COND_ALWAYS,        STEP_IDLE};
      STEP_DIV_INIT: w = '{OP_DIV_INIT,   COND_NEVER,         STEP_IDLE};
      STEP_DIV_STEP: w = '{OP_DIV_STEP,   COND_DIV_MORE,      STEP_DIV_STEP};
      STEP_PUSH:     w = '{OP_PUSH,       COND_MORE_QUOTIENT, STEP_DIV_INIT};
      STEP_SIGN:     w = '{OP_EMIT_SIGN,  COND_NEVER,         STEP_IDLE};
      STEP_DIGIT:    w = '{OP_EMIT_DIGIT, COND_MORE_DIGITS,   STEP_DIGIT};
      STEP_RETURN:   w = '{OP_NOP,        COND_ALWAYS,        STEP_IDLE};
      default:       w = '{OP_NOP,        COND_ALWAYS,        STEP_IDLE};
    endcase
    return w;
  endfunction

  // True for a byte that may not appear in the alphabet.
  function automatic logic symbol_forbidden(input logic [CHAR_W-1:0] c);
    return (c == CHAR_NUL) || ((c >= CHAR_TAB) && (c <= CHAR_CR)) ||
           (c == CHAR_SPACE) || (c == CHAR_MINUS) || (c == CHAR_PLUS);
  endfunction

endpackage

### rtl/core/sird_divider.sv
module sird_divider #(
  parameter int MAX_RADIX = sird_pkg::MAX_RADIX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sird_pkg::div_ctl_t                  ctl,
  input  logic [sird_pkg::VALUE_W-1:0]        dividend,
  input  logic [sird_pkg::RADIX_W-1:0]        divisor,
  output logic [sird_pkg::VALUE_W-1:0]        quotient,
  output logic [$clog2(MAX_RADIX)-1:0]        remainder,
  output logic                                last_step
);
  import sird_pkg::*;

  localparam int REM_W = $clog2(MAX_RADIX);
  localparam int TW    = RADIX_W + 1;

  logic [BITCNT_W-1:0] bitcnt;
  logic [REM_W:0]      trial;
  logic [TW-1:0]       trial_ext;
  logic [TW-1:0]       diff;
  logic                fits;

  // Restoring division, one quotient bit per step; the quotient shifts into the dividend.
  assign trial     = {remainder, quotient[VALUE_W-1]};
  assign trial_ext = TW'(trial);
  assign fits      = trial_ext >= TW'(divisor);
  assign diff      = trial_ext - TW'(divisor);
  assign last_step = (bitcnt == '1);

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      bitcnt <= '0;
    end else if (ctl.init) begin
      bitcnt <= '0;
    end else if (ctl.step) begin
      bitcnt <= bitcnt + 1'b1;
    end
  end

  // Quotient and partial remainder.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      quotient <= dividend;
    end else if (ctl.step) begin
      quotient <= {quotient[VALUE_W-2:0], fits};
    end
    if (ctl.init) begin
      remainder <= '0;
    end else if (ctl.step) begin
      remainder <= fits ? REM_W'(diff) : REM_W'(trial);
    end
  end

endmodule

### rtl/core/signed_integer_to_radix_digits_core.sv
// Writes a signed 32-bit value as characters in a configured radix, most
// significant digit first, with a leading '-' for a negative value.
// Input channel: value_valid, value_stall, value. Once it accepts a beat, the
// block stalls the input until the sequencer is back at idle: through the
// return step after the last character, or straight after an error beat.
// Output channel: result_valid, result_stall, character, last, bad_alphabet.
// One beat per character; last marks the final one. If the alphabet is bad
// (radix out of range, a forbidden or repeated symbol), one beat with
// character 0, last and bad_alphabet set is sent instead.
// Steps: a microcoded sequencer runs a load step, an alphabet check of one
// symbol per step and a test step, then for each digit a divider init step,
// the bit-serial divider steps and a push step, then a sign step, the digit
// output steps and a return step; a bad alphabet goes to an error step.
// The next value is accepted only once the sequencer is back at idle, so the
// block does not take a new value before it is through with the last one.
// A stall on the output holds the sequencer at the emitting step.
// Reset (rst, synchronous) puts the sequencer at its idle step, empties the
// output register and restores radix 10 with the symbols '0' to '7' and '9'
// twice, rejected as a repeat until rewritten. The user writes the registers
// via cfg_write, cfg_index and cfg_data only while idle; this is not enforced.
`include "signed_integer_to_radix_digits_core_assert.svh"

module signed_integer_to_radix_digits_core #(
  parameter int MAX_RADIX = sird_pkg::MAX_RADIX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sird_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sird_pkg::SYM_W-1:0]          cfg_data,
  input  logic                                value_valid,
  output logic                                value_stall,
  input  logic signed [sird_pkg::VALUE_W-1:0] value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [sird_pkg::CHAR_W-1:0]         character,
  output logic                                last,
  output logic                                bad_alphabet
);
  import sird_pkg::*;

  localparam int REM_W = $clog2(MAX_RADIX);

  // Configuration registers.
  logic [RADIX_W-1:0]  radix;
  logic [SYM_W-1:0]    symbols_low;
  logic [SYM_W-1:0]    symbols_high;
  logic [2*SYM_W-1:0]  sym_bus;
  logic [CHAR_W-1:0]   syms [NUM_SYMS];

  // Sequencer.
  logic [PC_W-1:0]     pc;
  logic [PC_W-1:0]     pc_next;
  ctrl_word_t          cw;
  logic                taken;
  logic                hold;

  // Datapath state.
  logic                neg;
  logic                bad;
  logic [SYM_IDX_W-1:0] chk_idx;
  logic [ND_W-1:0]     nd;
  logic [ND_W-1:0]     nd_m1;
  logic [REM_W-1:0]    digits [MAX_DIGITS];
  logic [REM_W-1:0]    digit_rd;
  logic [SYM_IDX_W-1:0] sym_sel;

  // Divider link.
  div_ctl_t            div_ctl;
  logic [VALUE_W-1:0]  magnitude;
  logic [VALUE_W-1:0]  quotient;
  logic [REM_W-1:0]    remainder;
  logic                div_last;

  // Alphabet check and output handshake.
  logic [CHAR_W-1:0]   cur_sym;
  logic                in_use;
  logic                dup;
  logic                sym_bad;
  logic                accept;
  logic                out_free;
  logic                emit_req;
  logic                range_bad;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix        <= RADIX_RESET;
      symbols_low  <= SYMBOLS_LOW_RESET;
      symbols_high <= SYMBOLS_HIGH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RADIX:        radix        <= cfg_data[RADIX_W-1:0];
        CFG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        CFG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the alphabet into symbols.
  assign sym_bus = {symbols_high, symbols_low};
  always_comb begin
    for (int i = 0; i < NUM_SYMS; i++) begin
      syms[i] = sym_bus[CHAR_W*i +: CHAR_W];
    end
  end

  // Current control word and input handshake.
  assign cw          = ucode_rom(pc);
  assign value_stall = (pc != STEP_IDLE);
  assign accept      = value_valid && !value_stall;

  // Magnitude of the input in 32 bits; the most negative value maps to itself.
  assign magnitude = value[VALUE_W-1] ? (~value + 1'b1) : value;
  assign range_bad = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_RADIX));

  // One symbol per check step against the symbols above it.
  assign cur_sym = syms[chk_idx];
  assign in_use  = {1'b0, chk_idx} < radix;
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < NUM_SYMS; j++) begin
      if ((SYM_IDX_W'(j) > chk_idx) && (RADIX_W'(j) < radix) && (syms[j] == cur_sym)) begin
        dup = 1'b1;
      end
    end
  end
  assign sym_bad = in_use && (symbol_forbidden(cur_sym) || dup);

  // Output register is free when empty or being taken.
  assign out_free = !result_valid || !result_stall;
  assign emit_req = (cw.op == OP_EMIT_ERR) || (cw.op == OP_EMIT_DIGIT) ||
                    ((cw.op == OP_EMIT_SIGN) && neg);
  assign hold     = emit_req && !out_free;

  // Digit read for output, newest digit first.
  assign nd_m1    = nd - 1'b1;
  assign digit_rd = digits[nd_m1[DIGIT_IDX_W-1:0]];
  assign sym_sel  = SYM_IDX_W'(digit_rd);

  // Jump condition.
  always_comb begin
    case (cw.cond)
      COND_NEVER:         taken = 1'b0;
      COND_ALWAYS:        taken = 1'b1;
      COND_NO_INPUT:      taken = !value_valid;
      COND_CHECK_MORE:    taken = (chk_idx != '1);
      COND_ALPHA_OK:      taken = !bad;
      COND_DIV_MORE:      taken = !div_last;
      COND_MORE_QUOTIENT: taken = (quotient != '0) && (nd != ND_W'(MAX_DIGITS - 1));
      COND_MORE_DIGITS:   taken = (nd != ND_W'(1));
      default:            taken = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Divider strobes.
  assign div_ctl.load = (cw.op == OP_LOAD) && accept;
  assign div_ctl.init = (cw.op == OP_DIV_INIT);
  assign div_ctl.step = (cw.op == OP_DIV_STEP);

  sird_divider #(
    .MAX_RADIX (MAX_RADIX)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .dividend  (magnitude),
    .divisor   (radix),
    .quotient  (quotient),
    .remainder (remainder),
    .last_step (div_last)
  );

  // Sign, alphabet flag, check index and digit count.
  always_ff @(posedge clk) begin
    if (rst) begin
      nd      <= '0;
      chk_idx <= '0;
      bad     <= 1'b0;
      neg     <= 1'b0;
    end else begin
      case (cw.op)
        OP_LOAD: begin
          if (accept) begin
            neg     <= value[VALUE_W-1];
            nd      <= '0;
            chk_idx <= '0;
            bad     <= range_bad;
          end
        end
        OP_CHECK: begin
          bad     <= bad | sym_bad;
          chk_idx <= chk_idx + 1'b1;
        end
        OP_PUSH: begin
          nd <= nd + 1'b1;
        end
        OP_EMIT_DIGIT: begin
          if (!hold) begin
            nd <= nd_m1;
          end
        end
        default: ;
      endcase
    end
  end

  // Digit store, least significant digit at the bottom.
  always_ff @(posedge clk) begin
    if (cw.op == OP_PUSH) begin
      digits[nd[DIGIT_IDX_W-1:0]] <= remainder;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_req && !hold) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_req && !hold) begin
      case (cw.op)
        OP_EMIT_ERR: begin
          character    <= CHAR_NUL;
          last         <= 1'b1;
          bad_alphabet <= 1'b1;
        end
        OP_EMIT_SIGN: begin
          character    <= CHAR_MINUS;
          last         <= 1'b0;
          bad_alphabet <= 1'b0;
        end
        default: begin
          character    <= syms[sym_sel];
          last         <= (nd == ND_W'(1));
          bad_alphabet <= 1'b0;
        end
      endcase
    end
  end

  // An error beat is always the final beat of its value.
  `SIRD_ASSERT_IMPLY(a_bad_is_last, clk, rst, result_valid && bad_alphabet, last)
  // A finished division leaves a remainder below the radix.
  `SIRD_ASSERT_IMPLY(a_rem_in_range, clk, rst, cw.op == OP_PUSH, RADIX_W'(remainder) < radix)
  // A digit is only pushed while the store has room for it.
  `SIRD_ASSERT_IMPLY(a_push_room, clk, rst, cw.op == OP_PUSH, nd < ND_W'(MAX_DIGITS))
  // Digits are only read out while the store holds some.
  `SIRD_ASSERT_IMPLY(a_digit_count, clk, rst, cw.op == OP_EMIT_DIGIT,
                     nd != '0 && nd <= ND_W'(MAX_DIGITS))
  // An accepted value always starts the alphabet check.
  `SIRD_ASSERT_NEXT(a_accept_to_check, clk, rst, accept, pc == STEP_CHECK && chk_idx == '0)

endmodule

### tb/digit_stream_checker.sv
`timescale 1ns / 100ps

module digit_stream_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sird_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sird_pkg::SYM_W-1:0]          cfg_data,
  input  logic                                value_valid,
  input  logic                                value_stall,
  input  logic signed [sird_pkg::VALUE_W-1:0] value,
  input  logic                                result_valid,
  input  logic                                result_stall,
  input  logic [sird_pkg::CHAR_W-1:0]         character,
  input  logic                                last,
  input  logic                                bad_alphabet,
  output int                                  outstanding,
  output int                                  mismatches
);
  import sird_pkg::*;

  // One character beat as the block should send it.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
    logic              bad;
  } char_beat_t;

  // Shadow copy of the configuration registers.
  logic [RADIX_W-1:0] radix_q = RADIX_RESET;
  logic [SYM_W-1:0]   low_q   = SYMBOLS_LOW_RESET;
  logic [SYM_W-1:0]   high_q  = SYMBOLS_HIGH_RESET;

  char_beat_t pending_chars[$];
  int         errors_seen = 0;

  assign mismatches = errors_seen;

  function automatic logic [CHAR_W-1:0] symbol(input int i);
    logic [2*SYM_W-1:0] both;
    both = {high_q, low_q};
    return both[i*CHAR_W +: CHAR_W];
  endfunction

  // The alphabet is usable when the radix is in range and the symbols in use
  // are distinct and contain no blank, sign or zero byte.
  function automatic logic alphabet_usable();
    int                n;
    logic [CHAR_W-1:0] c;
    n = int'(radix_q);
    if (n < 2 || n > MAX_RADIX_DEF) return 1'b0;
    for (int i = 0; i < n; i++) begin
      c = symbol(i);
      if (c == CHAR_NUL || (c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE ||
          c == CHAR_MINUS || c == CHAR_PLUS) return 1'b0;
      for (int j = i + 1; j < n; j++) begin
        if (symbol(j) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Queue the characters that spell one value in the current radix.
  function automatic void spell_value(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0]   mag;
    logic [VALUE_W-1:0]   base;
    logic [SYM_IDX_W-1:0] digs [MAX_DIGITS];
    int                   nd;
    if (!alphabet_usable()) begin
      pending_chars.push_back('{CHAR_NUL, 1'b1, 1'b1});
      return;
    end
    base = VALUE_W'(radix_q);
    // The 32-bit negation of the most negative value is its own magnitude.
    mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
    nd = 0;
    do begin
      digs[nd] = SYM_IDX_W'(mag % base);
      mag = mag / base;
      nd++;
    end while (mag != 0 && nd < MAX_DIGITS);
    if (v[VALUE_W-1]) pending_chars.push_back('{CHAR_MINUS, 1'b0, 1'b0});
    for (int k = nd - 1; k >= 0; k--) begin
      pending_chars.push_back('{symbol(digs[k]), (k == 0), 1'b0});
    end
  endfunction

  // Compare output beats first, then predict from input beats, then track
  // register writes so that a write lands after this edge.
  always @(posedge clk) begin : watch
    char_beat_t want;
    if (rst) begin
      pending_chars.delete();
      radix_q <= RADIX_RESET;
      low_q   <= SYMBOLS_LOW_RESET;
      high_q  <= SYMBOLS_HIGH_RESET;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_chars.size() == 0) begin
          $error("character: no beat expected, got %02h", character);
          errors_seen++;
        end else begin
          want = pending_chars.pop_front();
          if (character !== want.ch) begin
            $error("character: expected %02h, got %02h", want.ch, character);
            errors_seen++;
          end
          if (last !== want.fin) begin
            $error("last: expected %0b, got %0b", want.fin, last);
            errors_seen++;
          end
          if (bad_alphabet !== want.bad) begin
            $error("bad_alphabet: expected %0b, got %0b", want.bad, bad_alphabet);
            errors_seen++;
          end
        end
      end
      if (value_valid && !value_stall) spell_value(value);
      if (cfg_write) begin
        case (cfg_index)
          CFG_RADIX:        radix_q <= cfg_data[RADIX_W-1:0];
          CFG_SYMBOLS_LOW:  low_q   <= cfg_data;
          CFG_SYMBOLS_HIGH: high_q  <= cfg_data;
          default: ;
        endcase
      end
    end
    outstanding <= pending_chars.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sird_pkg::*;

  // Bound for the watchdog; all items of the run, even at the slowest radix
  // and with output stalls, fit well inside it.
  localparam int CYCLE_LIMIT   = 2_000_000;
  // After its last digit beat the sequencer passes its return step before it is back at idle.
  localparam int SETTLE_CYCLES = 8;

  localparam logic [SYM_W-1:0] HEX_LOW  = 64'h3736353433323130;
  localparam logic [SYM_W-1:0] HEX_HIGH = 64'h4645444342413938;

  localparam logic [CHAR_W-1:0] FORBIDDEN_BYTES [9] = '{
    CHAR_NUL, CHAR_TAB, 8'd10, 8'd11, 8'd12, CHAR_CR, CHAR_SPACE, CHAR_MINUS, CHAR_PLUS
  };

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index    = CFG_RADIX;
  logic [SYM_W-1:0]          cfg_data     = '0;
  logic                      value_valid  = 1'b0;
  logic signed [VALUE_W-1:0] value        = '0;
  logic                      result_stall = 1'b0;
  logic                      value_stall;
  logic                      result_valid;
  logic [CHAR_W-1:0]         character;
  logic                      last;
  logic                      bad_alphabet;
  int                        outstanding;
  int                        mismatches;

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int cycle_count     = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  signed_integer_to_radix_digits_core uut (.*);

  digit_stream_checker digits_chk (.*);

  // Receiver stalls at random at the current rate.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SYM_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write all three registers; the radix word carries junk above its field.
  task automatic load_alphabet(input logic [RADIX_W-1:0] r, input logic [SYM_W-1:0] lo,
                               input logic [SYM_W-1:0] hi);
    logic [SYM_W-1:0] word;
    word = {$urandom, $urandom};
    word[RADIX_W-1:0] = r;
    write_reg(CFG_RADIX, word);
    write_reg(CFG_SYMBOLS_LOW, lo);
    write_reg(CFG_SYMBOLS_HIGH, hi);
    cfg_write <= 1'b0;
  endtask

  // Hold off the sender until every expected character has come out.
  task automatic settle();
    value_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Present one value, with random idle cycles ahead of it, and wait for the beat.
  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      value_valid <= 1'b0;
      value       <= $urandom;
      @(posedge clk);
    end
    value_valid <= 1'b1;
    value       <= v;
    @(posedge clk);
    while (value_stall) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(5))
      0: v = $urandom >> $urandom_range(31);
      1: v = -($urandom >> $urandom_range(31));
      2: begin
        case ($urandom_range(3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Distinct legal symbols in the used positions, any byte above them.
  function automatic void build_alphabet(input int r, output logic [2*SYM_W-1:0] syms);
    logic [CHAR_W-1:0] c;
    logic              clash;
    syms = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < r && i < NUM_SYMS; i++) begin
      do begin
        // Legal ranges lie between the control bytes, blanks and signs.
        case ($urandom_range(5))
          0: c = CHAR_W'($urandom_range(1, 8));
          1: c = CHAR_W'($urandom_range(14, 31));
          2: c = CHAR_W'($urandom_range(33, 42));
          3: c = CHAR_W'($urandom_range(46, 127));
          default: c = CHAR_W'($urandom_range(128, 255));
        endcase
        clash = 1'b0;
        for (int j = 0; j < i; j++) begin
          if (syms[j*CHAR_W +: CHAR_W] == c) clash = 1'b1;
        end
      end while (clash);
      syms[i*CHAR_W +: CHAR_W] = c;
    end
  endfunction

  // New random setting; about one in seven is broken on purpose.
  task automatic random_setting();
    int                 r;
    int                 p;
    int                 q;
    logic [2*SYM_W-1:0] syms;
    case ($urandom_range(5))
      0: r = 2;
      1: r = NUM_SYMS;
      default: r = $urandom_range(3, NUM_SYMS - 1);
    endcase
    build_alphabet(r, syms);
    if ($urandom_range(99) < 15) begin
      p = $urandom_range(r - 1);
      case ($urandom_range(2))
        0: r = $urandom_range(1) ? $urandom_range(17, 31) : $urandom_range(0, 1);
        1: syms[p*CHAR_W +: CHAR_W] = FORBIDDEN_BYTES[$urandom_range(8)];
        default: begin
          q = (p + 1 + $urandom_range(r - 2)) % r;
          syms[p*CHAR_W +: CHAR_W] = syms[q*CHAR_W +: CHAR_W];
        end
      endcase
    end
    settle();
    load_alphabet(r[RADIX_W-1:0], syms[SYM_W-1:0], syms[2*SYM_W-1:SYM_W]);
  endtask

  initial begin
    logic [2*SYM_W-1:0] syms;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // The reset alphabet repeats '9', so these all come back as error beats.
    send_value(32'sd0);
    send_value(-32'sd1);
    send_value(32'sd10);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(32'sh5555_5555);
    send_value(32'shAAAA_AAAA);

    // Largest and smallest radix.
    settle();
    load_alphabet(5'd16, HEX_LOW, HEX_HIGH);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(32'sh0123_4567);
    settle();
    load_alphabet(5'd2, HEX_LOW, HEX_HIGH);
    send_value(32'sh8000_0000);

    // Unused positions hold forbidden bytes and must be ignored.
    settle();
    load_alphabet(5'd3, 64'h2B2D_200D_097A_6261, '0);
    send_value(-32'sd7);

    // Radix out of range.
    settle();
    load_alphabet(5'd0, SYMBOLS_LOW_RESET, SYMBOLS_HIGH_RESET);
    send_value(random_value());
    settle();
    load_alphabet(5'd1, SYMBOLS_LOW_RESET, SYMBOLS_HIGH_RESET);
    send_value(random_value());
    settle();
    load_alphabet(5'd17, HEX_LOW, HEX_HIGH);
    send_value(random_value());
    settle();
    load_alphabet(5'd31, HEX_LOW, HEX_HIGH);
    send_value(random_value());

    // Each forbidden byte in a used position of an otherwise clean alphabet.
    for (int i = 0; i < 9; i++) begin
      syms = {HEX_HIGH, HEX_LOW};
      syms[i*CHAR_W +: CHAR_W] = FORBIDDEN_BYTES[i];
      settle();
      load_alphabet(5'd10, syms[SYM_W-1:0], syms[2*SYM_W-1:SYM_W]);
      send_value(random_value());
    end

    // Last symbol repeats the first.
    settle();
    load_alphabet(5'd16, HEX_LOW, {HEX_LOW[CHAR_W-1:0], HEX_HIGH[SYM_W-CHAR_W-1:0]});
    send_value(random_value());

    // Random part, one phase per idling pattern.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct <= 0;  end
        1: begin sender_idle_pct = 60; stall_pct <= 0;  end
        2: begin sender_idle_pct = 0;  stall_pct <= 60; end
        default: begin sender_idle_pct = 36; stall_pct <= 36; end
      endcase
      for (int s = 0; s < 6; s++) begin
        random_setting();
        for (int n = 0; n < 10; n++) begin
          if ($urandom_range(19) == 0) settle();
          send_value(random_value());
        end
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### signed_integer_to_radix_digits_core.f
+incdir+rtl/core
rtl/core/sird_pkg.sv
rtl/core/sird_divider.sv
rtl/core/signed_integer_to_radix_digits_core.sv
tb/digit_stream_checker.sv
tb/tb_top.sv
